// File: rtl/jds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jds_pkg: shared types and constants of the joystick dead-zone scaler
// Field widths, scaling constants, register indexes, the controller command
// bundle and the result record.
// ----------------------------------------------------------------------------
package jds_pkg;

	// field widths
	localparam int IN_W       = 12;
	localparam int LVL_W      = 10;
	localparam int SPD_W      = 11;
	localparam int PTR_W      = 6;
	localparam int BAR_W      = 8;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// divider geometry: every quotient here stays below 2**QUO_W
	localparam int NUM_W     = 22;
	localparam int DEN_W     = 13;
	localparam int QUO_W     = 10;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// scaling constants
	localparam int DEAD_BAND         = 50;
	localparam int POINTER_LENGTH    = 22;
	localparam int AXIS_FULL         = 999;
	localparam int LEVEL_FULL_OPEN   = 999;
	localparam int LEVEL_SPAN_CLOSED = 150;
	localparam int LEVEL_BASE_CLOSED = 50;
	localparam int BAR_SHIFT         = 7;
	localparam int ADC_FULL          = 4096;
	localparam int ADC_SHIFT         = 12;
	localparam int PTR_DIVISOR       = 1000;
	localparam int PTR_MAX           = 31;
	localparam int PTR_MIN           = -32;
	localparam int CENTER_RESET      = 2050;

	// pointer offset as speed * PTR_RECIP >> PTR_RECIP_SHIFT; the rounded-up
	// reciprocal of 1000 keeps the floor exact for speeds up to 999
	localparam int PTR_RECIP_SHIFT = 25;
	localparam int PTR_RECIP       = POINTER_LENGTH
		* ((2**PTR_RECIP_SHIFT + PTR_DIVISOR - 1) / PTR_DIVISOR);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd2;

	// axis lanes
	localparam int LANE_Y = 0;
	localparam int LANE_X = 1;

	typedef struct packed {
		logic capture;    // take the input item
		logic prep;       // form products, offsets, bar update
		logic axis_load;  // start axis divisions
		logic ptr_load;   // latch axis magnitudes for speeds and pointers
		logic div_step;   // advance both dividers one bit
		logic out_load;   // fill the output register
	} jds_cmd_t;

	typedef struct packed {
		logic        [BAR_W-1:0] prev_bar_b;
		logic        [BAR_W-1:0] prev_bar_a;
		logic        [BAR_W-1:0] bar_b;
		logic        [BAR_W-1:0] bar_a;
		logic signed [PTR_W-1:0] pointer_y;
		logic signed [PTR_W-1:0] pointer_x;
		logic signed [SPD_W-1:0] speed_x;
		logic signed [SPD_W-1:0] speed_y;
		logic        [LVL_W-1:0] level_b;
		logic        [LVL_W-1:0] level_a;
	} jds_result_t;

endpackage

// File: rtl/jds_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jds_div: bit-serial restoring divider
// Unsigned quotient of QUO_W bits, one bit per step, divisor pre-shifted.
// ----------------------------------------------------------------------------
module jds_div (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        step,
	input  logic [jds_pkg::NUM_W-1:0]   num,
	input  logic [jds_pkg::DEN_W-1:0]   den,
	output logic [jds_pkg::QUO_W-1:0]   quo
);

	logic [jds_pkg::NUM_W-1:0] rem_q;
	logic [jds_pkg::NUM_W-1:0] dsh_q;
	logic [jds_pkg::QUO_W-1:0] quo_q;
	logic                      fits;

	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= num;
			dsh_q <= jds_pkg::NUM_W'(den) << (jds_pkg::QUO_W - 1);
			quo_q <= '0;
		end else if (step) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[jds_pkg::QUO_W-2:0], fits};
		end
	end

	assign quo = quo_q;

endmodule

// File: rtl/jds_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jds_ctrl: sequencing state machine
// Walks one item through prep, axis division, magnitude latch and output.
// ----------------------------------------------------------------------------
module jds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output jds_pkg::jds_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_PREP    = 3'd1;
	localparam logic [2:0] ST_AXIS_LD = 3'd2;
	localparam logic [2:0] ST_AXIS    = 3'd3;
	localparam logic [2:0] ST_PTR_LD  = 3'd4;
	localparam logic [2:0] ST_FIN     = 3'd5;

	logic [2:0]                state_q;
	logic [2:0]                state_nxt;
	logic [jds_pkg::CNT_W-1:0] cnt_q;
	logic                      out_valid_q;
	logic                      last_step;

	assign last_step = cnt_q == jds_pkg::CNT_W'(jds_pkg::DIV_STEPS - 1);
	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep  = 1'b1;
				state_nxt = ST_AXIS_LD;
			end
			ST_AXIS_LD: begin
				cmd.axis_load = 1'b1;
				state_nxt     = ST_AXIS;
			end
			ST_AXIS: begin
				cmd.div_step = 1'b1;
				if (last_step) begin
					state_nxt = ST_PTR_LD;
				end
			end
			ST_PTR_LD: begin
				cmd.ptr_load = 1'b1;
				state_nxt    = ST_FIN;
			end
			ST_FIN: begin
				// wait for the output register to drain
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.div_step && !last_step) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/jds_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jds_datapath: scaling datapath
// Configuration registers, level and bar scaling, two axis lanes with a
// serial divider each, and the output register.
// ----------------------------------------------------------------------------
module jds_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  jds_pkg::jds_cmd_t                cmd,
	input  logic                             cfg_we,
	input  logic [jds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jds_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [4*jds_pkg::IN_W-1:0]       in_data,
	input  logic                             in_update,
	output jds_pkg::jds_result_t             result
);

	localparam int IN_W  = jds_pkg::IN_W;
	localparam int NUM_W = jds_pkg::NUM_W;
	localparam int DEN_W = jds_pkg::DEN_W;
	localparam int QUO_W = jds_pkg::QUO_W;
	localparam int SPD_W = jds_pkg::SPD_W;
	localparam int PTR_W = jds_pkg::PTR_W;
	localparam int BAR_W = jds_pkg::BAR_W;

	// floor(x / 4095), exact while the quotient stays below 2**QUO_W
	function automatic logic [QUO_W-1:0] div4095(input logic [NUM_W-1:0] x);
		logic [NUM_W:0] s;
		s = {1'b0, x} + (NUM_W+1)'(x >> jds_pkg::ADC_SHIFT) + (NUM_W+1)'(1);
		return s[jds_pkg::ADC_SHIFT +: QUO_W];
	endfunction

	logic [jds_pkg::MODE_W-1:0] mode_q;
	logic [IN_W-1:0]            center_q   [2];
	logic [BAR_W-1:0]           bar_a_q;
	logic [BAR_W-1:0]           bar_b_q;
	logic [BAR_W-1:0]           old_bar_a_q;
	logic [BAR_W-1:0]           old_bar_b_q;

	logic [IN_W-1:0]            pot_a_q;
	logic [IN_W-1:0]            pot_b_q;
	logic [IN_W-1:0]            stick_q    [2];
	logic                       upd_q;

	logic [NUM_W-1:0]           lev_a_q;
	logic [NUM_W-1:0]           lev_b_q;
	logic                       closed_q;
	logic [NUM_W-1:0]           lane_num_q [2];
	logic [DEN_W-1:0]           lane_den_q [2];
	logic                       lane_neg_q [2];
	logic                       lane_act_q [2];
	logic [QUO_W-1:0]           lane_mag_q [2];

	logic signed [DEN_W-1:0]    diff       [2];
	logic [IN_W-1:0]            mag        [2];
	logic [DEN_W-1:0]           den        [2];
	logic [QUO_W-1:0]           quo        [2];
	logic [QUO_W-1:0]           mag_eff    [2];
	logic [31:0]                ptr_prod   [2];
	logic [QUO_W-1:0]           ptr_mag    [2];
	logic signed [SPD_W-1:0]    axis_val   [2];
	logic signed [SPD_W-1:0]    ptr_wide   [2];
	logic signed [PTR_W-1:0]    ptr_val    [2];
	logic [NUM_W-1:0]           lev_a_prod;
	logic [NUM_W-1:0]           lev_b_prod;
	logic [QUO_W-1:0]           base;

	// lane arithmetic
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			diff[l] = $signed({1'b0, stick_q[l]}) - $signed({1'b0, center_q[l]});
			mag[l]  = diff[l][DEN_W-1] ? IN_W'(-diff[l]) : IN_W'(diff[l]);
			if (diff[l][DEN_W-1]) begin
				den[l] = DEN_W'(center_q[l]);
			end else begin
				den[l] = DEN_W'(jds_pkg::ADC_FULL) - DEN_W'(center_q[l]);
			end
			if (den[l] == '0) begin
				den[l] = DEN_W'(1);
			end

			mag_eff[l] = lane_act_q[l] ? quo[l] : '0;

			// floor(speed * POINTER_LENGTH / 1000) by reciprocal multiply
			ptr_prod[l] = 32'(lane_mag_q[l]) * 32'(jds_pkg::PTR_RECIP);
			ptr_mag[l]  = QUO_W'(ptr_prod[l] >> jds_pkg::PTR_RECIP_SHIFT);

			// axis sign follows the offset; the pointer takes the opposite sign
			axis_val[l] = lane_neg_q[l] ? -$signed({1'b0, lane_mag_q[l]})
				: $signed({1'b0, lane_mag_q[l]});
			ptr_wide[l] = lane_neg_q[l] ? $signed({1'b0, ptr_mag[l]})
				: -$signed({1'b0, ptr_mag[l]});
			if (ptr_wide[l] > $signed(SPD_W'(jds_pkg::PTR_MAX))) begin
				ptr_val[l] = PTR_W'(jds_pkg::PTR_MAX);
			end else if (ptr_wide[l] < $signed(SPD_W'(jds_pkg::PTR_MIN))) begin
				ptr_val[l] = PTR_W'(jds_pkg::PTR_MIN);
			end else begin
				ptr_val[l] = ptr_wide[l][PTR_W-1:0];
			end
		end
	end

	assign lev_a_prod = (mode_q != '0)
		? NUM_W'(pot_a_q) * NUM_W'(jds_pkg::LEVEL_SPAN_CLOSED)
		: NUM_W'(pot_a_q) * NUM_W'(jds_pkg::LEVEL_FULL_OPEN);
	assign lev_b_prod = (mode_q != '0)
		? NUM_W'(pot_b_q) * NUM_W'(jds_pkg::LEVEL_SPAN_CLOSED)
		: NUM_W'(pot_b_q) * NUM_W'(jds_pkg::LEVEL_FULL_OPEN);
	assign base = closed_q ? QUO_W'(jds_pkg::LEVEL_BASE_CLOSED) : '0;

	jds_div u_div_y (
		.clk  (clk),
		.load (cmd.axis_load),
		.step (cmd.div_step),
		.num  (lane_num_q[jds_pkg::LANE_Y]),
		.den  (lane_den_q[jds_pkg::LANE_Y]),
		.quo  (quo[jds_pkg::LANE_Y])
	);

	jds_div u_div_x (
		.clk  (clk),
		.load (cmd.axis_load),
		.step (cmd.div_step),
		.num  (lane_num_q[jds_pkg::LANE_X]),
		.den  (lane_den_q[jds_pkg::LANE_X]),
		.quo  (quo[jds_pkg::LANE_X])
	);

	// configuration and bar state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q                   <= '0;
			center_q[jds_pkg::LANE_Y] <= IN_W'(jds_pkg::CENTER_RESET);
			center_q[jds_pkg::LANE_X] <= IN_W'(jds_pkg::CENTER_RESET);
			bar_a_q                  <= '0;
			bar_b_q                  <= '0;
			old_bar_a_q              <= '0;
			old_bar_b_q              <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					jds_pkg::CFG_MODE:     mode_q <= cfg_data[jds_pkg::MODE_W-1:0];
					jds_pkg::CFG_CENTER_X: center_q[jds_pkg::LANE_X] <= cfg_data;
					jds_pkg::CFG_CENTER_Y: center_q[jds_pkg::LANE_Y] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.prep && upd_q) begin
				old_bar_a_q <= bar_a_q;
				old_bar_b_q <= bar_b_q;
				bar_a_q     <= BAR_W'(div4095(NUM_W'(pot_a_q) << jds_pkg::BAR_SHIFT));
				bar_b_q     <= BAR_W'(div4095(NUM_W'(pot_b_q) << jds_pkg::BAR_SHIFT));
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pot_a_q                  <= in_data[0*IN_W +: IN_W];
			pot_b_q                  <= in_data[1*IN_W +: IN_W];
			stick_q[jds_pkg::LANE_Y] <= in_data[2*IN_W +: IN_W];
			stick_q[jds_pkg::LANE_X] <= in_data[3*IN_W +: IN_W];
			upd_q                    <= in_update;
		end
		if (cmd.prep) begin
			lev_a_q  <= lev_a_prod;
			lev_b_q  <= lev_b_prod;
			closed_q <= mode_q != '0;
			for (int l = 0; l < 2; l++) begin
				lane_num_q[l] <= NUM_W'(mag[l]) * NUM_W'(jds_pkg::AXIS_FULL);
				lane_den_q[l] <= den[l];
				lane_neg_q[l] <= diff[l][DEN_W-1];
				lane_act_q[l] <= (diff[l] > $signed(DEN_W'(jds_pkg::DEAD_BAND)))
					|| (diff[l] < -$signed(DEN_W'(jds_pkg::DEAD_BAND)));
			end
		end
		if (cmd.ptr_load) begin
			for (int l = 0; l < 2; l++) begin
				lane_mag_q[l] <= mag_eff[l];
			end
		end
		if (cmd.out_load) begin
			result.level_a    <= div4095(lev_a_q) + base;
			result.level_b    <= div4095(lev_b_q) + base;
			result.speed_y    <= axis_val[jds_pkg::LANE_Y];
			result.speed_x    <= -axis_val[jds_pkg::LANE_X];
			result.pointer_y  <= ptr_val[jds_pkg::LANE_Y];
			result.pointer_x  <= ptr_val[jds_pkg::LANE_X];
			result.bar_a      <= bar_a_q;
			result.bar_b      <= bar_b_q;
			result.prev_bar_a <= old_bar_a_q;
			result.prev_bar_b <= old_bar_b_q;
		end
	end

endmodule

// File: rtl/joystick_deadzone_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_deadzone_scaler: potentiometer levels, dead-banded stick speeds
// Scales two potentiometers to a mode range, turns two stick axes into
// signed speeds with a dead band around the calibrated center, derives
// pointer offsets and keeps current and previous bar lengths.
// ----------------------------------------------------------------------------
//
// channel  direction  handshake                   payload
// s_axis   in         s_axis_tvalid/tready        tdata: sample set, tuser: update_bars
// m_axis   out        m_axis_tvalid/tready        tdata: levels, speeds, pointers, bars
// cfg      in         cfg_valid/cfg_ready         cfg_index, cfg_data
//
// An item goes from acceptance to a loaded output register through capture,
// prep, a divider load, ten quotient steps of the per-axis serial dividers,
// a latch of the speed magnitudes, then the output load; pointer offsets
// come from a reciprocal multiply during the output load.
// The next item is accepted the cycle after the load, while the result may
// still wait in the output register; a full output register holds the
// finished item back. Reset clears control, mode and bars and sets both
// centers to 2050. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module joystick_deadzone_scaler (
	input  logic                               clk,
	input  logic                               arst_n,
	// stick_x, stick_y, pot_b, pot_a from the top down (pot_a in bits 11:0)
	input  logic [4*jds_pkg::IN_W-1:0]         s_axis_tdata,
	// update_bars
	input  logic                               s_axis_tuser,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// level_a, level_b, speed_y, speed_x, pointer_x, pointer_y, bar_a,
	// bar_b, prev_bar_a, prev_bar_b from bit 0 up, two zero bits on top
	output logic [87:0]                        m_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [jds_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jds_pkg::CFG_DATA_W-1:0]     cfg_data
);

	jds_pkg::jds_cmd_t    cmd;
	jds_pkg::jds_result_t result;

	// registers live in the datapath, so a write is always taken at once
	assign cfg_ready = 1'b1;

	jds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	jds_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_update (s_axis_tuser),
		.result    (result)
	);

	// pack the result, first field in the lowest bits
	assign m_axis_tdata = {
		2'b00,
		result.prev_bar_b,
		result.prev_bar_a,
		result.bar_b,
		result.bar_a,
		result.pointer_y,
		result.pointer_x,
		result.speed_x,
		result.speed_y,
		result.level_b,
		result.level_a
	};

endmodule
